[rtl/tccw_pkg.sv]
// ============================================================================
// tccw_pkg
// Types, codes and constants shared by the text console cell writer modules.
// ============================================================================
package tccw_pkg;

    localparam int unsigned ADDR_W  = 11;
    localparam int unsigned DIV_W   = 32;
    localparam int unsigned REM_W   = 5;
    localparam int unsigned RADIX_W = 5;
    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned STACK_AW = 5;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [4:0] DIGIT_MAX    = 5'd9;
    localparam logic [4:0] RADIX_MIN    = 5'd2;
    localparam logic [4:0] RADIX_MAX    = 5'd16;
    localparam int unsigned BG_SHIFT    = 4;

    localparam logic [3:0] FG_RESET = 4'd15;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef enum logic [0:0] {
        CFG_FG_COLOR = 1'b0,
        CFG_BG_COLOR = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_PUT_CHAR   = 1'b0,
        OP_PUT_NUMBER = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        EMIT_NONE  = 2'd0,
        EMIT_CHAR  = 2'd1,
        EMIT_SIGN  = 2'd2,
        EMIT_DIGIT = 2'd3
    } emit_src_t;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         char_code;
        logic signed [31:0] number;
        logic [4:0]         radix;
    } request_t;

    typedef struct packed {
        logic [10:0] cell_address;
        logic [7:0]  glyph;
        logic [7:0]  attribute;
        logic        off_screen;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic      load_item;
        logic      newline;
        logic      div_step;
        logic      store_digit;
        logic      load_ptr;
        logic      dec_ptr;
        emit_src_t emit_src;
        logic      emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_number;
        logic is_newline;
        logic negative;
        logic div_last_step;
        logic quo_zero;
        logic stack_full;
        logic ptr_zero;
        logic out_free;
    } dp_status_t;

    function automatic logic [7:0] digit_glyph(input logic [4:0] digit);
        logic [7:0] value;
        value = {3'b000, digit};
        if (digit > DIGIT_MAX) begin
            return 8'(CHAR_LOWER_A + value - 8'd10);
        end
        return 8'(CHAR_ZERO + value);
    endfunction

endpackage

[rtl/tccw_ctrl.sv]
// ============================================================================
// tccw_ctrl
// Sequencer for the console writer: accepts a transaction, runs the digit
// divider, and steps the datapath through the cell writes.
// ============================================================================
module tccw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  request_valid,
    output logic                  ready,
    input  tccw_pkg::dp_status_t  status,
    output tccw_pkg::ctrl_cmd_t   command
);
    import tccw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_DIV,
        ST_STORE,
        ST_SIGN,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        command    = '0;
        command.emit_src = EMIT_NONE;
        ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (request_valid)
                begin
                    command.load_item = 1'b1;
                    if (status.is_number)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (status.is_newline)
                    begin
                        command.newline = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_CHAR;
                    end
                end
            end
            ST_CHAR:
            begin
                if (status.out_free)
                begin
                    command.emit_src  = EMIT_CHAR;
                    command.emit_last = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                command.div_step = 1'b1;
                if (status.div_last_step)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                command.store_digit = 1'b1;
                if (status.quo_zero || status.stack_full)
                begin
                    command.load_ptr = 1'b1;
                    state_next = status.negative ? ST_SIGN : ST_FETCH;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    command.emit_src = EMIT_SIGN;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    command.emit_src  = EMIT_DIGIT;
                    command.emit_last = status.ptr_zero;
                    if (status.ptr_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        command.dec_ptr = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/tccw_dp.sv]
// ============================================================================
// tccw_dp
// Datapath of the console writer: cursor, colors, radix divider, digit
// stack and the result register.
// ============================================================================
module tccw_dp #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tccw_pkg::request_t    request,
    input  logic                  cfg_write_enable,
    input  logic [0:0]            cfg_index,
    input  logic [3:0]            cfg_data,
    input  tccw_pkg::ctrl_cmd_t   command,
    output tccw_pkg::dp_status_t  status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output tccw_pkg::result_t     result
);
    import tccw_pkg::*;

    localparam int unsigned ROW_W = $clog2(ROWS + 1);
    localparam int unsigned COL_W = $clog2(COLUMNS + 1);
    localparam logic [ROW_W-1:0]  ROW_LIMIT = ROW_W'(ROWS);
    localparam logic [COL_W-1:0]  COL_LIMIT = COL_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ADDR_W-1:0]   base_reg;
    logic [ADDR_W-1:0]   base_next;
    logic [3:0]          fg_reg;
    logic [3:0]          bg_reg;

    logic [7:0]          char_reg;
    logic                neg_reg;
    logic [RADIX_W-1:0]  radix_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [4:0]          step_reg;
    logic [STACK_AW-1:0] count_reg;
    logic [STACK_AW-1:0] ptr_reg;

    logic [7:0]          stack_mem [STACK_DEPTH];
    logic [7:0]          rd_data_reg;

    logic                out_valid_reg;
    result_t             out_reg;

    logic [DIV_W-1:0]    in_mag;
    logic [RADIX_W-1:0]  in_radix;
    logic [REM_W:0]      trial;
    logic                trial_ge;
    logic                emit;
    logic                off;
    logic [COL_W-1:0]    col_inc;
    logic [7:0]          glyph_sel;

    assign in_mag = request.number[31] ? (32'd0 - 32'(request.number))
                                       : 32'(request.number);

    always_comb
    begin
        in_radix = request.radix;
        if (request.radix < RADIX_MIN)
        begin
            in_radix = RADIX_MIN;
        end
        else if (request.radix > RADIX_MAX)
        begin
            in_radix = RADIX_MAX;
        end
    end

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, radix_reg};

    assign emit    = command.emit_src != EMIT_NONE;
    assign off     = row_reg >= ROW_LIMIT;
    assign col_inc = col_reg + 1'b1;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        base_next = base_reg;
        if (command.newline || (emit && (col_inc >= COL_LIMIT)))
        begin
            col_next = '0;
            if (row_reg < ROW_LIMIT)
            begin
                row_next  = row_reg + 1'b1;
                base_next = base_reg + ROW_STEP;
            end
        end
        else if (emit)
        begin
            col_next = col_inc;
        end
    end

    always_comb
    begin
        case (command.emit_src)
            EMIT_CHAR:  glyph_sel = char_reg;
            EMIT_SIGN:  glyph_sel = CHAR_MINUS;
            EMIT_DIGIT: glyph_sel = rd_data_reg;
            default:    glyph_sel = char_reg;
        endcase
    end

    always_comb
    begin
        status.is_number     = request.cmd == OP_PUT_NUMBER;
        status.is_newline    = request.char_code == CHAR_NEWLINE;
        status.negative      = neg_reg;
        status.div_last_step = step_reg == 5'd31;
        status.quo_zero      = quo_reg == '0;
        status.stack_full    = count_reg == STACK_AW'(STACK_DEPTH - 1);
        status.ptr_zero      = ptr_reg == '0;
        status.out_free      = !out_valid_reg || !result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            base_reg <= base_next;
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    CFG_FG_COLOR: fg_reg <= cfg_data;
                    CFG_BG_COLOR: bg_reg <= cfg_data;
                    default:      fg_reg <= fg_reg;
                endcase
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (command.load_item)
        begin
            char_reg  <= request.char_code;
            neg_reg   <= request.number[31];
            radix_reg <= in_radix;
            quo_reg   <= in_mag;
            rem_reg   <= '0;
            step_reg  <= '0;
            count_reg <= '0;
        end
        if (command.div_step)
        begin
            quo_reg  <= {quo_reg[DIV_W-2:0], trial_ge};
            rem_reg  <= trial_ge ? REM_W'(trial - {1'b0, radix_reg}) : trial[REM_W-1:0];
            step_reg <= step_reg + 1'b1;
        end
        if (command.store_digit)
        begin
            stack_mem[count_reg] <= digit_glyph(rem_reg);
            count_reg <= count_reg + 1'b1;
            rem_reg   <= '0;
            step_reg  <= '0;
        end
        if (command.load_ptr)
        begin
            ptr_reg <= count_reg;
        end
        else if (command.dec_ptr)
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
        rd_data_reg <= stack_mem[ptr_reg];
        if (emit)
        begin
            out_reg.cell_address <= off ? '0 : ADDR_W'(base_reg + ADDR_W'(col_reg));
            out_reg.glyph        <= glyph_sel;
            out_reg.attribute    <= {bg_reg, fg_reg};
            out_reg.off_screen   <= off;
            out_reg.last_of_run  <= command.emit_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[rtl/text_console_cell_writer.sv]
// ============================================================================
// text_console_cell_writer
// Writes characters and signed integers into a ROWS x COLUMNS text grid,
// one result transaction per cell; the cursor column wraps to the next row.
// ============================================================================
// A character is accepted and then, once the result register is free, loaded
// into it; a newline is accepted and moves the cursor without writing a
// cell. A number is converted by a restoring divider that produces one
// quotient bit per cycle, so each digit takes 32 divide steps and one store
// into the digit stack; the digits are then read back from the stack, each
// fetched and then emitted once the result register is free, after a minus
// sign if the number is negative. A new request is taken only after the
// previous one has produced its last cell; the result register lets that last
// cell wait while the next request is accepted. Cells written past the last
// row carry off_screen and address zero.
module text_console_cell_writer #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_stall,
    input  tccw_pkg::request_t  request,
    output logic                result_valid,
    input  logic                result_stall,
    output tccw_pkg::result_t   result,
    input  logic                cfg_write_enable,
    input  logic [0:0]          cfg_index,
    input  logic [3:0]          cfg_data
);
    import tccw_pkg::*;

    ctrl_cmd_t  command;
    dp_status_t status;
    logic       ready;

    assign request_stall = !ready;

    tccw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .ready         (ready),
        .status        (status),
        .command       (command)
    );

    tccw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .request          (request),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .status           (status),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result           (result)
    );

endmodule

[rtl/tccw_checker.sv]
// ============================================================================
// tccw_checker
// Port-level checks for the text console cell writer, bound to the top level.
// ============================================================================
module tccw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                request_valid,
    input logic                request_stall,
    input tccw_pkg::request_t  request,
    input logic                result_valid,
    input logic                result_stall,
    input tccw_pkg::result_t   result
);
    import tccw_pkg::*;

    // A stalled result transaction holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result payload changed while stalled");

    // Cells that fall past the last row carry address zero.
    a_off_screen_addr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.off_screen |-> result.cell_address == '0)
        else $error("off-screen cell has a nonzero address");

    // While the block takes requests, any waiting cell closes its run.
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        !request_stall && result_valid |-> result.last_of_run)
        else $error("block idle with an unfinished run");

    // A stalled request transaction holds its payload.
    a_request_hold: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && request_stall |=> request_valid && $stable(request))
        else $error("request payload changed while stalled");

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (.*);

[sim/tccw_cell_checker.sv]
// ----------------------------------------------------------------------------
// Cell writer checker
// Watches the request, result and register ports of the text console cell
// writer. It keeps its own cursor and colors, works out the cells that each
// accepted request must write, and compares every result transaction with
// the oldest cell still due.
// ----------------------------------------------------------------------------
module tccw_cell_checker #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    input  logic                request_stall,
    input  tccw_pkg::request_t  request,
    input  logic                result_valid,
    input  logic                result_stall,
    input  tccw_pkg::result_t   result,
    input  logic                cfg_write_enable,
    input  logic [0:0]          cfg_index,
    input  logic [3:0]          cfg_data,
    output int                  fail_count,
    output int                  cells_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tccw_pkg::*;

    logic [4:0] row_pos;
    logic [6:0] col_pos;
    logic [3:0] fg_now;
    logic [3:0] bg_now;
    result_t    cells_due[$];

    function automatic void next_row();
        if (row_pos < ROWS)
        begin
            row_pos = row_pos + 5'd1;
        end
    endfunction

    function automatic void emit_cell(input logic [7:0] glyph, input logic last);
        result_t due;
        due.off_screen   = (row_pos >= ROWS);
        due.cell_address = due.off_screen ? '0 : 11'(row_pos * COLUMNS + col_pos);
        due.glyph        = glyph;
        due.attribute    = {bg_now, fg_now};
        due.last_of_run  = last;
        cells_due.push_back(due);
        col_pos = col_pos + 7'd1;
        if (col_pos >= COLUMNS)
        begin
            col_pos = '0;
            next_row();
        end
    endfunction

    function automatic void plan_cells(input request_t req);
        logic [7:0]  digits [32];
        logic [31:0] mag;
        logic [31:0] rem;
        logic [4:0]  base;
        logic        negative;
        int          count;
        if (req.cmd == OP_PUT_CHAR)
        begin
            if (req.char_code == CHAR_NEWLINE)
            begin
                next_row();
                col_pos = '0;
            end
            else
            begin
                emit_cell(req.char_code, 1'b1);
            end
            return;
        end
        base = req.radix;
        if (base < RADIX_MIN)
        begin
            base = RADIX_MIN;
        end
        if (base > RADIX_MAX)
        begin
            base = RADIX_MAX;
        end
        negative = req.number[31];
        mag      = negative ? (32'd0 - req.number) : req.number;
        count    = 0;
        do
        begin
            rem = mag % base;
            mag = mag / base;
            digits[count] = (rem > DIGIT_MAX) ? CHAR_LOWER_A + 8'(rem) - 8'd10
                                              : CHAR_ZERO + 8'(rem);
            count++;
        end
        while (mag != 0 && count < 32);
        if (negative)
        begin
            emit_cell(CHAR_MINUS, 1'b0);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            emit_cell(digits[i], i == 0);
        end
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t due;
        if (!rst_n)
        begin
            row_pos    = '0;
            col_pos    = '0;
            fg_now     = FG_RESET;
            bg_now     = BG_RESET;
            fail_count = 0;
            cells_due.delete();
        end
        else
        begin
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    CFG_FG_COLOR: fg_now = cfg_data;
                    CFG_BG_COLOR: bg_now = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (cells_due.size() == 0)
                begin
                    $error("cell transaction with nothing due: address %0d glyph %0d",
                           result.cell_address, result.glyph);
                    fail_count++;
                end
                else
                begin
                    due = cells_due.pop_front();
                    compare_field("cell_address", 32'(due.cell_address),
                                  32'(result.cell_address));
                    compare_field("glyph", 32'(due.glyph), 32'(result.glyph));
                    compare_field("attribute", 32'(due.attribute),
                                  32'(result.attribute));
                    compare_field("off_screen", 32'(due.off_screen),
                                  32'(result.off_screen));
                    compare_field("last_of_run", 32'(due.last_of_run),
                                  32'(result.last_of_run));
                end
            end
            if (request_valid && !request_stall)
            begin
                plan_cells(request);
            end
        end
        cells_pending = cells_due.size();
    end

endmodule

[sim/text_console_cell_writer_tb.sv]
// ----------------------------------------------------------------------------
// Text console cell writer testbench
// Sends characters, newlines and signed numbers in varied radices to the cell
// writer in random bursts while the result side stalls on its own pattern.
// The colors are changed between phases, and the run ends by pushing the
// cursor past the last row. The checker beside the block does the compare.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tccw_pkg::*;

    localparam int unsigned COLUMNS        = 80;
    localparam int unsigned ROWS           = 25;
    localparam int          PHASE_ITEMS    = 90;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       request_valid;
    logic       request_stall;
    request_t   request;
    logic       result_valid;
    logic       result_stall;
    result_t    result;
    logic       cfg_write_enable;
    logic [0:0] cfg_index;
    logic [3:0] cfg_data;
    int         fail_count;
    int         cells_pending;
    int         idle_cycles;
    int         burst_left;

    text_console_cell_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .request_valid   (request_valid),
        .request_stall   (request_stall),
        .request         (request),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_write_enable(cfg_write_enable),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    tccw_cell_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) cell_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .request_valid   (request_valid),
        .request_stall   (request_stall),
        .request         (request),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_write_enable(cfg_write_enable),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .cells_pending   (cells_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write_enable || (request_valid && !request_stall)
            || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int run_len;
        int stall_pct;
        result_stall = 1'b0;
        forever
        begin
            run_len = $urandom_range(5, 60);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat (run_len)
            begin
                @(negedge clk);
                result_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic request_t char_request(input logic [7:0] code);
        request_t req;
        req.cmd       = OP_PUT_CHAR;
        req.char_code = code;
        req.number    = $urandom;
        req.radix     = 5'($urandom_range(0, 31));
        return req;
    endfunction

    function automatic request_t number_request(input logic [31:0] value,
                                                input logic [4:0] base);
        request_t req;
        req.cmd       = OP_PUT_NUMBER;
        req.char_code = 8'($urandom_range(0, 255));
        req.number    = value;
        req.radix     = base;
        return req;
    endfunction

    function automatic request_t random_request();
        request_t    req;
        logic [31:0] value;
        logic [4:0]  base;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            return char_request(CHAR_NEWLINE);
        end
        if (pick < 55)
        begin
            return char_request(8'($urandom_range(0, 255)));
        end
        value = $urandom;
        case ($urandom_range(0, 5))
            0: value = 32'($urandom_range(0, 100)) - 32'd50;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7fff_ffff;
                    2: value = 32'hffff_ffff;
                    default: value = 32'd0;
                endcase
            end
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: base = 5'd10;
            1: base = 5'd16;
            2: base = 5'd8;
            default: base = 5'($urandom_range(0, 31));
        endcase
        req = number_request(value, base);
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input request_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                request_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        request       <= req;
        request_valid <= 1'b1;
        do @(posedge clk); while (request_stall);
        @(negedge clk);
    endtask

    task automatic wait_until_settled();
        request_valid <= 1'b0;
        burst_left = 0;
        while (cells_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        cfg_write_enable <= 1'b1;
        cfg_index        <= CFG_FG_COLOR;
        cfg_data         <= fg;
        @(negedge clk);
        cfg_index        <= CFG_BG_COLOR;
        cfg_data         <= bg;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_phase(input logic [3:0] fg, input logic [3:0] bg);
        set_colors(fg, bg);
        repeat (PHASE_ITEMS) send_request(random_request());
        wait_until_settled();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        request_valid    = 1'b0;
        request          = '0;
        cfg_write_enable = 1'b0;
        cfg_index        = CFG_FG_COLOR;
        cfg_data         = '0;
        burst_left       = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Short directed set with the colors left at their reset values.
        send_request(char_request(8'h00));
        send_request(char_request(8'hff));
        send_request(char_request(8'h41));
        send_request(char_request(CHAR_NEWLINE));
        send_request(number_request(32'd0, 5'd10));
        send_request(number_request(32'h7fff_ffff, 5'd10));
        send_request(number_request(32'h8000_0000, 5'd10));
        send_request(number_request(32'h8000_0000, 5'd2));
        send_request(number_request(32'h7fff_ffff, 5'd2));
        send_request(number_request(32'hffff_ffff, 5'd16));
        send_request(number_request(32'd255, 5'd16));
        send_request(number_request(32'hdead_beef, 5'd16));
        send_request(number_request(-32'sd12345, 5'd8));
        send_request(number_request(32'd5, 5'd0));
        send_request(number_request(32'd5, 5'd1));
        send_request(number_request(32'd1000, 5'd17));
        send_request(number_request(32'hffff_0000, 5'd31));
        send_request(number_request(32'd35, 5'd20));
        send_request(number_request(32'd123456789, 5'd3));
        send_request(char_request(CHAR_NEWLINE));
        send_request(char_request(CHAR_NEWLINE));
        send_request(char_request(8'h7e));
        wait_until_settled();

        random_phase(4'd0, 4'd15);
        random_phase(4'd15, 4'd15);
        random_phase(4'd0, 4'd0);
        random_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));

        // Drive the cursor below the last row and keep writing there.
        set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        repeat (ROWS + 1)
        begin
            send_request(char_request(CHAR_NEWLINE));
            send_request(random_request());
        end
        send_request(number_request(32'h8000_0000, 5'd2));
        repeat (20) send_request(random_request());
        wait_until_settled();
        repeat (40) @(negedge clk);

        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
